### rtl/bmf_pkg.sv
`timescale 1ns / 1ps

package bmf_pkg;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 1024;
    localparam int RADIUS      = 7;
    localparam int WIN         = 2 * RADIUS + 1;
    localparam int DIVISOR     = WIN * WIN;
    localparam int PADW        = MAX_WIDTH + RADIUS;
    localparam int LS_DEPTH    = WIN * PADW;
    localparam int LS_AW       = $clog2(LS_DEPTH);
    localparam int COL_AW      = $clog2(PADW);
    localparam int ROW_W       = $clog2(MAX_HEIGHT + RADIUS);
    localparam int SLOT_W      = $clog2(WIN);
    localparam int PIX_W       = 8;
    localparam int CS_W        = 12;
    localparam int WS_W        = 16;
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int PROD_W      = 32;

    localparam int WIDTH_W     = 10;
    localparam int HEIGHT_W    = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(416);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(240);

    // one classified position, front to back
    typedef struct packed {
        logic [PIX_W-1:0]  v;
        logic [LS_AW-1:0]  ls_addr;
        logic [COL_AW-1:0] col;
        logic              r_zero;
        logic              r_ge_win;
        logic              c_zero;
        logic              c_ge_win;
        logic              emit;
        logic              last;
    } t_work;

endpackage

### rtl/box_mean_filter_15x15.sv
`timescale 1ns / 1ps
// Channel   Handshake                    Beat
// --------  ---------------------------  ------------------------------
// input     push / full                  i_op, i_pixel
// result    empty / pop                  o_mean, o_frame_last
// config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One beat per cycle in and out while full and empty stay low.
// The back end runs a fixed five-stage pipe (memory read, column sum,
// window sum, reciprocal multiply, result queue) fed from a 4-deep queue.
// Issue waits for work and for an unreserved slot in the 8-deep result queue.
// No reset clearing pass; cfg is always ready; size writes restart the frame.

module box_mean_filter_15x15 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_op,
    input  logic [7:0]                     i_pixel,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     o_mean,
    output logic                           o_frame_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bmf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bmf_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    t_work q_in;
    t_work q_out;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;

    bmf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_op        (i_op),
        .i_pixel     (i_pixel),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_in)
    );

    bmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    bmf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (q_valid),
        .i_work       (q_out),
        .o_work_pop   (q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_mean       (o_mean),
        .o_frame_last (o_frame_last)
    );

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_pop_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("back end took from an empty work queue");

    a_push_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("front end pushed into a full work queue");

endmodule

### rtl/bmf_front.sv
`timescale 1ns / 1ps

module bmf_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_op,
    input  logic [7:0]                     i_pixel,
    input  logic                           i_cfg_valid,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bmf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output bmf_pkg::t_work                 o_q_data
);
    import bmf_pkg::*;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [ROW_W-1:0]    r_row;
    logic [COL_AW-1:0]   r_col;
    logic [SLOT_W-1:0]   r_slot;
    logic [LS_AW-1:0]    r_base;

    logic [WIDTH_W-1:0]  w_clamp;
    logic [HEIGHT_W-1:0] h_clamp;
    logic [COL_AW-1:0]   padw_m1;
    logic [ROW_W-1:0]    padh_m1;
    logic                col_last;
    logic                row_last;
    logic                accept;

    always_comb begin
        if (r_width == '0) begin
            w_clamp = WIDTH_W'(1);
        end else if (r_width > WIDTH_W'(MAX_WIDTH)) begin
            w_clamp = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_clamp = r_width;
        end
        if (r_height == '0) begin
            h_clamp = HEIGHT_W'(1);
        end else if (r_height > HEIGHT_W'(MAX_HEIGHT)) begin
            h_clamp = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            h_clamp = r_height;
        end
    end

    assign padw_m1  = COL_AW'(w_clamp) + COL_AW'(RADIUS - 1);
    assign padh_m1  = ROW_W'(h_clamp) + ROW_W'(RADIUS - 1);
    assign col_last = (r_col == padw_m1);
    assign row_last = (r_row == padh_m1);
    assign accept   = i_push && !i_q_full;

    assign o_q_push         = accept;
    assign o_q_data.v       = i_op ? '0 : i_pixel;
    assign o_q_data.ls_addr = r_base + LS_AW'(r_col);
    assign o_q_data.col     = r_col;
    assign o_q_data.r_zero  = (r_row == '0);
    assign o_q_data.r_ge_win = (r_row >= ROW_W'(WIN));
    assign o_q_data.c_zero  = (r_col == '0);
    assign o_q_data.c_ge_win = (r_col >= COL_AW'(WIN));
    assign o_q_data.emit    = (r_row >= ROW_W'(RADIUS)) && (r_col >= COL_AW'(RADIUS));
    assign o_q_data.last    = row_last && col_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_row    <= '0;
            r_col    <= '0;
            r_slot   <= '0;
            r_base   <= '0;
        end else if (i_cfg_valid) begin
            // a width or height write restarts the frame
            if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data[WIDTH_W-1:0];
            end
            if (i_cfg_index == CFG_IMAGE_HEIGHT) begin
                r_height <= i_cfg_data[HEIGHT_W-1:0];
            end
            if (i_cfg_index == CFG_IMAGE_WIDTH || i_cfg_index == CFG_IMAGE_HEIGHT) begin
                r_row  <= '0;
                r_col  <= '0;
                r_slot <= '0;
                r_base <= '0;
            end
        end else if (accept) begin
            if (col_last) begin
                r_col <= '0;
                if (row_last) begin
                    r_row  <= '0;
                    r_slot <= '0;
                    r_base <= '0;
                end else begin
                    r_row <= r_row + ROW_W'(1);
                    if (r_slot == SLOT_W'(WIN - 1)) begin
                        r_slot <= '0;
                        r_base <= '0;
                    end else begin
                        r_slot <= r_slot + SLOT_W'(1);
                        r_base <= r_base + LS_AW'(PADW);
                    end
                end
            end else begin
                r_col <= r_col + COL_AW'(1);
            end
        end
    end

endmodule

### rtl/bmf_queue.sv
`timescale 1ns / 1ps

module bmf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bmf_pkg::t_work i_data,
    output logic           o_full,
    output logic           o_valid,
    output bmf_pkg::t_work o_data,
    input  logic           i_pop
);
    import bmf_pkg::*;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    t_work             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (Q_AW + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (Q_AW + 1)'(1);
            end
        end
    end

endmodule

### rtl/bmf_back.sv
`timescale 1ns / 1ps

module bmf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_work_valid,
    input  bmf_pkg::t_work i_work,
    output logic           o_work_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [7:0]     o_mean,
    output logic           o_frame_last
);
    import bmf_pkg::*;

    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);

    typedef struct packed {
        logic [CS_W-1:0] cs;
        logic            c_zero;
        logic            c_ge_win;
        logic            emit;
        logic            last;
    } t_tail;

    // line store and column sums
    logic [PIX_W-1:0] m_line [LS_DEPTH];
    logic [CS_W-1:0]  m_cols [PADW];

    logic             issue;
    logic [2:0]       pend;
    logic             r_s1_vld;
    t_work            r_s1;
    logic [PIX_W-1:0] r_ls_rd;
    logic [CS_W-1:0]  r_cs_rd;
    logic [CS_W-1:0]  cs_old;
    logic [CS_W-1:0]  ls_old;
    logic [CS_W-1:0]  n_cs;

    logic             r_s2_vld;
    t_tail            r_s2;
    logic [CS_W-1:0]  r_taps [WIN];
    logic [WS_W-1:0]  r_ws;
    logic [WS_W-1:0]  ws_base;
    logic [WS_W-1:0]  ws_drop;
    logic [WS_W-1:0]  n_ws;

    logic              r_s3_vld;
    logic              r_s3_last;
    logic              r_s4_vld;
    logic              r_s4_last;
    logic [PROD_W-1:0] r_prod;

    logic [7:0]        r_omean [OUT_DEPTH];
    logic              r_olast [OUT_DEPTH];
    logic [OUT_AW-1:0] r_owp;
    logic [OUT_AW-1:0] r_orp;
    logic [OUT_AW:0]   r_ocnt;
    logic              out_pop;

    // reserve an output slot for every result still in the pipe
    assign pend = 3'(r_s1_vld & r_s1.emit) + 3'(r_s2_vld & r_s2.emit)
                + 3'(r_s3_vld) + 3'(r_s4_vld);
    assign issue = i_work_valid &&
                   ((5'(r_ocnt) + 5'(pend)) < 5'(OUT_DEPTH));
    assign o_work_pop = issue;

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_ls_rd                <= m_line[i_work.ls_addr];
            m_line[i_work.ls_addr] <= i_work.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_cs_rd <= m_cols[i_work.col];
        end
        if (r_s1_vld) begin
            m_cols[r_s1.col] <= n_cs;
        end
    end

    // first row of a frame sees cleared column sums
    assign cs_old = r_s1.r_zero ? '0 : r_cs_rd;
    assign ls_old = r_s1.r_ge_win ? CS_W'(r_ls_rd) : '0;
    assign n_cs   = cs_old + CS_W'(r_s1.v) - ls_old;

    assign ws_base = r_s2.c_zero ? '0 : r_ws;
    assign ws_drop = r_s2.c_ge_win ? WS_W'(r_taps[WIN-1]) : '0;
    assign n_ws    = ws_base + WS_W'(r_s2.cs) - ws_drop;

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_s2.cs       <= n_cs;
            r_s2.c_zero   <= r_s1.c_zero;
            r_s2.c_ge_win <= r_s1.c_ge_win;
            r_s2.emit     <= r_s1.emit;
            r_s2.last     <= r_s1.last;
        end
        if (issue) begin
            r_s1 <= i_work;
        end
        if (r_s2_vld) begin
            r_taps[0] <= r_s2.cs;
            for (int i = 1; i < WIN; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
        end
        if (r_s3_vld) begin
            r_prod    <= PROD_W'({16'b0, r_ws} * PROD_W'(RECIP));
            r_s4_last <= r_s3_last;
        end
        if (r_s2_vld) begin
            r_s3_last <= r_s2.last;
        end
        if (r_s4_vld) begin
            r_omean[r_owp] <= r_prod[RECIP_SHIFT +: 8];
            r_olast[r_owp] <= r_s4_last;
        end
    end

    assign out_pop      = i_pop && (r_ocnt != '0);
    assign o_empty      = (r_ocnt == '0);
    assign o_mean       = r_omean[r_orp];
    assign o_frame_last = r_olast[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_ws     <= '0;
            r_owp    <= '0;
            r_orp    <= '0;
            r_ocnt   <= '0;
        end else begin
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld && r_s2.emit;
            r_s4_vld <= r_s3_vld;
            if (r_s2_vld) begin
                r_ws <= n_ws;
            end
            if (r_s4_vld) begin
                r_owp <= r_owp + OUT_AW'(1);
            end
            if (out_pop) begin
                r_orp <= r_orp + OUT_AW'(1);
            end
            if (r_s4_vld && !out_pop) begin
                r_ocnt <= r_ocnt + (OUT_AW + 1)'(1);
            end else if (out_pop && !r_s4_vld) begin
                r_ocnt <= r_ocnt - (OUT_AW + 1)'(1);
            end
        end
    end

endmodule
